// ----- design/psr_pkg.sv -----
package psr_pkg;

    localparam int PWM_BITS = 10;

    localparam int PCT_W   = 7;
    localparam int MS_W    = 16;
    localparam int RAW_W   = 10;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;
    localparam int STEP_W  = 5;
    localparam int DIVC_W  = $clog2(MS_W + 1);

    localparam int SCALE_W     = PWM_BITS + PCT_W;
    localparam int PCT_FULL    = 100;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = SCALE_W + RECIP_W;

    // ceil(2^30 / 100): exact floor division by 100 for products below 2^30 / 76
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + PCT_FULL - 1) / PCT_FULL);

    localparam logic [PCT_W-1:0] PCT_MAX   = PCT_W'(PCT_FULL);
    localparam logic [PCT_W-1:0] PCT_FLOOR = 7'd10;

    localparam logic [PCT_W-1:0] MAX_DUTY_RST   = 7'd100;
    localparam logic [MS_W-1:0]  SOFT_ON_RST    = 16'd1200;
    localparam logic [MS_W-1:0]  SOFT_OFF_RST   = 16'd800;
    localparam logic [PCT_W-1:0] KICK_LEVEL_RST = 7'd0;
    localparam logic [MS_W-1:0]  KICK_TIME_RST  = 16'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_DUTY   = 3'd0,
        REG_SOFT_ON    = 3'd1,
        REG_SOFT_OFF   = 3'd2,
        REG_KICK_LEVEL = 3'd3,
        REG_KICK_TIME  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ON   = 2'd1,
        OP_OFF  = 2'd2,
        OP_SET  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_KICK = 3'b010,
        PH_RAMP = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_ACCEPT    = 4'd1,
        ACT_SET_DUTY  = 4'd2,
        ACT_KICK      = 4'd3,
        ACT_LOAD_ON   = 4'd4,
        ACT_LOAD_OFF  = 4'd5,
        ACT_RAMP_NONE = 4'd6,
        ACT_DIV_INIT  = 4'd7,
        ACT_DIV_STEP  = 4'd8,
        ACT_RAMP_GO   = 4'd9,
        ACT_INC_MS    = 4'd10,
        ACT_IDLE      = 4'd11,
        ACT_STEP      = 4'd12,
        ACT_EMIT      = 4'd13
    } act_t;

    typedef enum logic [3:0] {
        C_ALWAYS    = 4'd0,
        C_IN_VALID  = 4'd1,
        C_OP_TICK   = 4'd2,
        C_OP_ON     = 4'd3,
        C_OP_OFF    = 4'd4,
        C_KICK_OK   = 4'd5,
        C_NO_RAMP   = 4'd6,
        C_DIV_LAST  = 4'd7,
        C_PH_KICK   = 4'd8,
        C_PH_RAMP   = 4'd9,
        C_AT_TARGET = 4'd10,
        C_STEP_DUE  = 4'd11,
        C_KICK_DONE = 4'd12,
        C_OUT_FREE  = 4'd13
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic              pol;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic op_tick;
        logic op_on;
        logic op_off;
        logic kick_ok;
        logic no_ramp;
        logic div_last;
        logic ph_kick;
        logic ph_ramp;
        logic at_target;
        logic step_due;
        logic kick_done;
        logic out_free;
    } flags_t;

    localparam logic [STEP_W-1:0] L_WAIT    = 5'd0;
    localparam logic [STEP_W-1:0] L_ON      = 5'd5;
    localparam logic [STEP_W-1:0] L_KICK    = 5'd7;
    localparam logic [STEP_W-1:0] L_OFF     = 5'd8;
    localparam logic [STEP_W-1:0] L_BEGIN   = 5'd9;
    localparam logic [STEP_W-1:0] L_DIV     = 5'd11;
    localparam logic [STEP_W-1:0] L_NORAMP  = 5'd13;
    localparam logic [STEP_W-1:0] L_TICK    = 5'd14;
    localparam logic [STEP_W-1:0] L_ENDRAMP = 5'd21;
    localparam logic [STEP_W-1:0] L_TKICK   = 5'd22;
    localparam logic [STEP_W-1:0] L_EMIT    = 5'd31;

    // Jump to target when the selected flag equals pol, else advance.
    // C_ALWAYS with pol 0 is a plain fall-through.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{act: ACT_NONE, cond: C_ALWAYS, pol: 1'b1, target: L_WAIT};
        unique case (step)
            5'd0:  w = '{act: ACT_ACCEPT,    cond: C_IN_VALID,  pol: 1'b0, target: L_WAIT};
            5'd1:  w = '{act: ACT_NONE,      cond: C_OP_TICK,   pol: 1'b1, target: L_TICK};
            5'd2:  w = '{act: ACT_NONE,      cond: C_OP_ON,     pol: 1'b1, target: L_ON};
            5'd3:  w = '{act: ACT_NONE,      cond: C_OP_OFF,    pol: 1'b1, target: L_OFF};
            5'd4:  w = '{act: ACT_SET_DUTY,  cond: C_ALWAYS,    pol: 1'b1, target: L_EMIT};
            5'd5:  w = '{act: ACT_NONE,      cond: C_KICK_OK,   pol: 1'b1, target: L_KICK};
            5'd6:  w = '{act: ACT_LOAD_ON,   cond: C_ALWAYS,    pol: 1'b1, target: L_BEGIN};
            5'd7:  w = '{act: ACT_KICK,      cond: C_ALWAYS,    pol: 1'b1, target: L_EMIT};
            5'd8:  w = '{act: ACT_LOAD_OFF,  cond: C_ALWAYS,    pol: 1'b1, target: L_BEGIN};
            5'd9:  w = '{act: ACT_NONE,      cond: C_NO_RAMP,   pol: 1'b1, target: L_NORAMP};
            5'd10: w = '{act: ACT_DIV_INIT,  cond: C_ALWAYS,    pol: 1'b0, target: L_WAIT};
            5'd11: w = '{act: ACT_DIV_STEP,  cond: C_DIV_LAST,  pol: 1'b0, target: L_DIV};
            5'd12: w = '{act: ACT_RAMP_GO,   cond: C_ALWAYS,    pol: 1'b1, target: L_EMIT};
            5'd13: w = '{act: ACT_RAMP_NONE, cond: C_ALWAYS,    pol: 1'b1, target: L_EMIT};
            5'd14: w = '{act: ACT_NONE,      cond: C_PH_KICK,   pol: 1'b1, target: L_TKICK};
            5'd15: w = '{act: ACT_NONE,      cond: C_PH_RAMP,   pol: 1'b0, target: L_EMIT};
            5'd16: w = '{act: ACT_NONE,      cond: C_AT_TARGET, pol: 1'b1, target: L_ENDRAMP};
            5'd17: w = '{act: ACT_INC_MS,    cond: C_ALWAYS,    pol: 1'b0, target: L_WAIT};
            5'd18: w = '{act: ACT_NONE,      cond: C_STEP_DUE,  pol: 1'b0, target: L_EMIT};
            5'd19: w = '{act: ACT_STEP,      cond: C_ALWAYS,    pol: 1'b0, target: L_WAIT};
            5'd20: w = '{act: ACT_NONE,      cond: C_AT_TARGET, pol: 1'b0, target: L_EMIT};
            5'd21: w = '{act: ACT_IDLE,      cond: C_ALWAYS,    pol: 1'b1, target: L_EMIT};
            5'd22: w = '{act: ACT_INC_MS,    cond: C_ALWAYS,    pol: 1'b0, target: L_WAIT};
            5'd23: w = '{act: ACT_NONE,      cond: C_KICK_DONE, pol: 1'b0, target: L_EMIT};
            5'd24: w = '{act: ACT_LOAD_ON,   cond: C_ALWAYS,    pol: 1'b1, target: L_BEGIN};
            // hold while the output word is full; the step counter wraps to wait
            5'd31: w = '{act: ACT_EMIT,      cond: C_OUT_FREE,  pol: 1'b0, target: L_EMIT};
            default: w = '{act: ACT_NONE,    cond: C_ALWAYS,    pol: 1'b1, target: L_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- design/psr_sequencer.sv -----
module psr_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  psr_pkg::flags_t  flags,
    output psr_pkg::uword_t  ctl
);

    logic [psr_pkg::STEP_W-1:0] step_reg;
    logic [psr_pkg::STEP_W-1:0] step_next;
    logic                       flag_sel;

    assign ctl = psr_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (ctl.cond)
            psr_pkg::C_ALWAYS:    flag_sel = 1'b1;
            psr_pkg::C_IN_VALID:  flag_sel = flags.in_valid;
            psr_pkg::C_OP_TICK:   flag_sel = flags.op_tick;
            psr_pkg::C_OP_ON:     flag_sel = flags.op_on;
            psr_pkg::C_OP_OFF:    flag_sel = flags.op_off;
            psr_pkg::C_KICK_OK:   flag_sel = flags.kick_ok;
            psr_pkg::C_NO_RAMP:   flag_sel = flags.no_ramp;
            psr_pkg::C_DIV_LAST:  flag_sel = flags.div_last;
            psr_pkg::C_PH_KICK:   flag_sel = flags.ph_kick;
            psr_pkg::C_PH_RAMP:   flag_sel = flags.ph_ramp;
            psr_pkg::C_AT_TARGET: flag_sel = flags.at_target;
            psr_pkg::C_STEP_DUE:  flag_sel = flags.step_due;
            psr_pkg::C_KICK_DONE: flag_sel = flags.kick_done;
            psr_pkg::C_OUT_FREE:  flag_sel = flags.out_free;
            default:              flag_sel = 1'b0;
        endcase
    end

    always_comb
    begin
        if (flag_sel == ctl.pol)
        begin
            step_next = ctl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= psr_pkg::L_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/psr_divider.sv -----
module psr_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       init,
    input  logic                       step,
    input  logic [psr_pkg::MS_W-1:0]   dividend,
    input  logic [psr_pkg::PCT_W-1:0]  divisor,
    output logic [psr_pkg::MS_W-1:0]   quotient,
    output logic                       last
);

    logic [psr_pkg::DIVC_W-1:0] cnt_reg;
    logic [psr_pkg::DIVC_W-1:0] cnt_next;
    logic [psr_pkg::MS_W-1:0]   quo_reg;
    logic [psr_pkg::MS_W-1:0]   quo_next;
    logic [psr_pkg::PCT_W-1:0]  rem_reg;
    logic [psr_pkg::PCT_W-1:0]  rem_next;
    logic [psr_pkg::PCT_W-1:0]  dvs_reg;
    logic [psr_pkg::PCT_W-1:0]  dvs_next;
    logic [psr_pkg::PCT_W:0]    trial;
    logic                       fits;

    assign trial    = {rem_reg, quo_reg[psr_pkg::MS_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign last     = cnt_reg == psr_pkg::DIVC_W'(1);

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (init)
        begin
            cnt_next = psr_pkg::DIVC_W'(psr_pkg::MS_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (step)
        begin
            // one quotient bit per cycle, restoring
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[psr_pkg::MS_W-2:0], fits};
            if (fits)
            begin
                rem_next = psr_pkg::PCT_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[psr_pkg::PCT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ----- design/psr_datapath.sv -----
module psr_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  psr_pkg::uword_t             ctl,
    output psr_pkg::flags_t             flags,
    input  logic                        cfg_we,
    input  logic [psr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [psr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [psr_pkg::PCT_W-1:0]   duty_request,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [psr_pkg::PCT_W-1:0]   duty_pct,
    output logic [psr_pkg::RAW_W-1:0]   duty_raw,
    output logic                        active,
    output logic                        busy_res
);

    // configuration
    logic [psr_pkg::PCT_W-1:0] max_duty_reg;
    logic [psr_pkg::MS_W-1:0]  soft_on_reg;
    logic [psr_pkg::MS_W-1:0]  soft_off_reg;
    logic [psr_pkg::PCT_W-1:0] kick_level_reg;
    logic [psr_pkg::MS_W-1:0]  kick_time_reg;
    logic [psr_pkg::PCT_W-1:0] cfg_pct;

    // working state
    logic [psr_pkg::PCT_W-1:0] duty_reg,     duty_next;
    psr_pkg::phase_t           phase_reg,    phase_next;
    logic [psr_pkg::PCT_W-1:0] target_reg,   target_next;
    logic                      up_reg,       up_next;
    logic [psr_pkg::MS_W-1:0]  interval_reg, interval_next;
    logic [psr_pkg::MS_W-1:0]  msc_reg,      msc_next;
    logic [psr_pkg::MS_W-1:0]  time_reg,     time_next;
    psr_pkg::opcode_t          op_reg,       op_next;
    logic [psr_pkg::PCT_W-1:0] req_reg,      req_next;

    // output word
    logic                      out_valid_reg, out_valid_next;
    logic [psr_pkg::PCT_W-1:0] pct_out_reg;
    logic [psr_pkg::RAW_W-1:0] raw_out_reg;
    logic                      active_reg;
    logic                      busy_reg;

    logic                       out_free;
    logic                       emit_fire;
    logic                       div_last;
    logic [psr_pkg::MS_W-1:0]   quotient;
    logic [psr_pkg::PCT_W-1:0]  span;
    logic [psr_pkg::SCALE_W-1:0] scaled;
    logic [psr_pkg::PROD_W-1:0] prod;

    assign in_stall    = ctl.act != psr_pkg::ACT_ACCEPT;
    assign out_free    = !out_valid_reg || !out_stall;
    assign emit_fire   = (ctl.act == psr_pkg::ACT_EMIT) && out_free;

    assign span = (target_reg > duty_reg) ? (target_reg - duty_reg) : (duty_reg - target_reg);

    psr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (ctl.act == psr_pkg::ACT_DIV_INIT),
        .step     (ctl.act == psr_pkg::ACT_DIV_STEP),
        .dividend (time_reg),
        .divisor  (span),
        .quotient (quotient),
        .last     (div_last)
    );

    always_comb
    begin
        flags.in_valid  = in_valid;
        flags.op_tick   = op_reg == psr_pkg::OP_TICK;
        flags.op_on     = op_reg == psr_pkg::OP_ON;
        flags.op_off    = op_reg == psr_pkg::OP_OFF;
        flags.kick_ok   = (kick_level_reg != '0) && (kick_time_reg != '0) && (duty_reg == '0);
        flags.no_ramp   = (time_reg == '0) || (duty_reg == target_reg);
        flags.div_last  = div_last;
        flags.ph_kick   = phase_reg == psr_pkg::PH_KICK;
        flags.ph_ramp   = phase_reg == psr_pkg::PH_RAMP;
        flags.at_target = duty_reg == target_reg;
        flags.step_due  = msc_reg >= interval_reg;
        flags.kick_done = msc_reg >= kick_time_reg;
        flags.out_free  = out_free;
    end

    // clamp the max duty write into its legal range
    always_comb
    begin
        cfg_pct = cfg_data[psr_pkg::PCT_W-1:0];
        if (cfg_pct < psr_pkg::PCT_FLOOR)
        begin
            cfg_pct = psr_pkg::PCT_FLOOR;
        end
        else if (cfg_pct > psr_pkg::PCT_MAX)
        begin
            cfg_pct = psr_pkg::PCT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg   <= psr_pkg::MAX_DUTY_RST;
            soft_on_reg    <= psr_pkg::SOFT_ON_RST;
            soft_off_reg   <= psr_pkg::SOFT_OFF_RST;
            kick_level_reg <= psr_pkg::KICK_LEVEL_RST;
            kick_time_reg  <= psr_pkg::KICK_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psr_pkg::REG_MAX_DUTY:   max_duty_reg   <= cfg_pct;
                psr_pkg::REG_SOFT_ON:    soft_on_reg    <= cfg_data[psr_pkg::MS_W-1:0];
                psr_pkg::REG_SOFT_OFF:   soft_off_reg   <= cfg_data[psr_pkg::MS_W-1:0];
                psr_pkg::REG_KICK_LEVEL: kick_level_reg <= cfg_data[psr_pkg::PCT_W-1:0];
                psr_pkg::REG_KICK_TIME:  kick_time_reg  <= cfg_data[psr_pkg::MS_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        duty_next     = duty_reg;
        phase_next    = phase_reg;
        target_next   = target_reg;
        up_next       = up_reg;
        interval_next = interval_reg;
        msc_next      = msc_reg;
        time_next     = time_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        unique case (ctl.act)
            psr_pkg::ACT_ACCEPT:
            begin
                if (in_valid)
                begin
                    op_next  = psr_pkg::opcode_t'(opcode);
                    req_next = duty_request;
                    // follow a lowered maximum
                    if (duty_reg > max_duty_reg)
                    begin
                        duty_next = max_duty_reg;
                    end
                    if (target_reg > max_duty_reg)
                    begin
                        target_next = max_duty_reg;
                    end
                end
            end
            psr_pkg::ACT_SET_DUTY:
            begin
                duty_next  = (req_reg > max_duty_reg) ? max_duty_reg : req_reg;
                phase_next = psr_pkg::PH_IDLE;
            end
            psr_pkg::ACT_KICK:
            begin
                duty_next  = (kick_level_reg > max_duty_reg) ? max_duty_reg : kick_level_reg;
                msc_next   = '0;
                phase_next = psr_pkg::PH_KICK;
            end
            psr_pkg::ACT_LOAD_ON:
            begin
                target_next = max_duty_reg;
                time_next   = soft_on_reg;
            end
            psr_pkg::ACT_LOAD_OFF:
            begin
                target_next = '0;
                time_next   = soft_off_reg;
            end
            psr_pkg::ACT_RAMP_NONE:
            begin
                duty_next  = target_reg;
                phase_next = psr_pkg::PH_IDLE;
            end
            psr_pkg::ACT_DIV_INIT:
            begin
                up_next = target_reg > duty_reg;
            end
            psr_pkg::ACT_RAMP_GO:
            begin
                interval_next = (quotient == '0) ? psr_pkg::MS_W'(1) : quotient;
                msc_next      = '0;
                phase_next    = psr_pkg::PH_RAMP;
            end
            psr_pkg::ACT_INC_MS:
            begin
                msc_next = msc_reg + 1'b1;
            end
            psr_pkg::ACT_IDLE:
            begin
                phase_next = psr_pkg::PH_IDLE;
            end
            psr_pkg::ACT_STEP:
            begin
                msc_next = '0;
                if (up_reg && (duty_reg < target_reg))
                begin
                    duty_next = duty_reg + 1'b1;
                end
                else if (!up_reg && (duty_reg > target_reg))
                begin
                    duty_next = duty_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg     <= '0;
            phase_reg    <= psr_pkg::PH_IDLE;
            target_reg   <= '0;
            up_reg       <= 1'b0;
            interval_reg <= psr_pkg::MS_W'(1);
            msc_reg      <= '0;
        end
        else
        begin
            duty_reg     <= duty_next;
            phase_reg    <= phase_next;
            target_reg   <= target_next;
            up_reg       <= up_next;
            interval_reg <= interval_next;
            msc_reg      <= msc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        op_reg   <= op_next;
        req_reg  <= req_next;
    end

    // raw = (2^PWM_BITS - 1) * pct / 100 via reciprocal multiply
    assign scaled = {duty_reg, psr_pkg::PWM_BITS'(0)} - psr_pkg::SCALE_W'(duty_reg);
    assign prod   = psr_pkg::PROD_W'(scaled) * psr_pkg::PROD_W'(psr_pkg::RECIP);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            pct_out_reg <= duty_reg;
            raw_out_reg <= prod[psr_pkg::RECIP_SHIFT +: psr_pkg::RAW_W];
            active_reg  <= duty_reg != '0;
            busy_reg    <= phase_reg != psr_pkg::PH_IDLE;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_pct  = pct_out_reg;
    assign duty_raw  = raw_out_reg;
    assign active    = active_reg;
    assign busy_res  = busy_reg;

endmodule

// ----- design/pwm_soft_start_ramp_unit.sv -----
// Soft start / soft stop ramp unit, one result word per input word.
// Each accepted word is decoded by opcode and its result word loads once the output word
// is free; a soft on or off that starts a ramp, or a tick that ends a kick into a ramp,
// first runs a bit-serial divide of the 16-bit ramp time by the span in steps.
// Throughput: one word at a time; the next is taken in the cycle after the result word loads.
// Reset (rst_n low, asynchronous): config registers return to defaults, duty zero, idle.
module pwm_soft_start_ramp_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [psr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [psr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [psr_pkg::PCT_W-1:0]   duty_request,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [psr_pkg::PCT_W-1:0]   duty_pct,
    output logic [psr_pkg::RAW_W-1:0]   duty_raw,
    output logic                        active,
    output logic                        busy_res
);

    psr_pkg::uword_t ctl;
    psr_pkg::flags_t flags;

    psr_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    psr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .flags        (flags),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .duty_request (duty_request),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty_pct     (duty_pct),
        .duty_raw     (duty_raw),
        .active       (active),
        .busy_res     (busy_res)
    );

endmodule
